// ----- src/i2rd_pkg.sv -----
// shared constants for the integer to radix digits converter
package i2rd_pkg;

  // default operand width of the converted integer
  localparam int unsigned VALUE_BITS_DEF = 32;

  // radix register and digit widths
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;

  // radix reset value and saturation bounds
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

endpackage

// ----- src/integer_to_radix_digits.sv -----
// signed integer to radix digit stream converter, top level
// a negative value adds a sign beat, zero skips the divider, output stalls hold the stream
// each digit costs one full pass of the bit-serial divider
// each output digit passes through S_FETCH and then S_SEND for the registered digit store read
// one item in flight; in_stall_o is low only while idle
// reset: asynchronous active low, radix returns to 10, digit store not cleared
module integer_to_radix_digits import i2rd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RADIX_W-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DIGIT_W-1:0]    digit_value_o,
  output logic                  is_minus_sign_o,
  output logic                  last_o
);

  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [RADIX_W-1:0]    base_q, base_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_nxt;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0]    out_digit_q, out_digit_d;
  logic                  out_minus_q, out_minus_d;
  logic                  out_last_q, out_last_d;
  logic                  out_load;
  logic                  out_free;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0]    base_sat;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DIGIT_W-1:0]    wr_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DIGIT_W-1:0]    rd_data_q;
  logic [CNT_W-1:0]      idx_dec;
  logic [DIGIT_W-1:0]    store_q [VALUE_BITS];

  // magnitude of the incoming value, most negative value maps to 2^(n-1)
  assign mag = value_i[VALUE_BITS-1] ? VALUE_BITS'(~value_i + 1'b1) : value_i;

  // radix saturated into 2..16
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      base_sat = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base_sat = RADIX_MAX;
    end else begin
      base_sat = radix_q;
    end
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign cnt_nxt      = cnt_q + 1'b1;
  assign idx_dec      = idx_q - 1'b1;
  assign rd_addr      = idx_dec[ADDR_W-1:0];
  assign div_dividend = (state_q == S_IDLE) ? mag : div_quot;

  // sequencer
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    div_start   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[ADDR_W-1:0];
    wr_data     = div_rem;
    out_load    = 1'b0;
    out_digit_d = out_digit_q;
    out_minus_d = out_minus_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          base_d = base_sat;
          neg_d  = value_i[VALUE_BITS-1];
          if (mag == '0) begin
            // zero gives a single 0 digit
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '0;
            cnt_d   = CNT_W'(1);
            idx_d   = CNT_W'(1);
            state_d = S_FETCH;
          end else begin
            div_start = 1'b1;
            cnt_d     = '0;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_en = 1'b1;
          cnt_d = cnt_nxt;
          if (div_quot == '0 || cnt_nxt == CNT_W'(VALUE_BITS)) begin
            idx_d   = cnt_nxt;
            state_d = neg_q ? S_SIGN : S_FETCH;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_digit_d = '0;
          out_minus_d = 1'b1;
          out_last_d  = 1'b0;
          state_d     = S_FETCH;
        end
      end
      S_FETCH: begin
        // store read address settles, data registered at this edge
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_digit_d = rd_data_q;
          out_minus_d = 1'b0;
          out_last_d  = idx_q == CNT_W'(1);
          idx_d       = idx_dec;
          state_d     = (idx_q == CNT_W'(1)) ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_RESET;
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    out_digit_q <= out_digit_d;
    out_minus_q <= out_minus_d;
    out_last_q  <= out_last_d;
  end

  // digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    rd_data_q <= store_q[rd_addr];
  end

  // shared divider
  i2rd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_start && state_q == S_IDLE ? base_sat : base_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign out_valid_o     = out_valid_q;
  assign digit_value_o   = out_digit_q;
  assign is_minus_sign_o = out_minus_q;
  assign last_o          = out_last_q;

endmodule

// ----- src/i2rd_div.sv -----
// iterative restoring divider, one quotient bit per cycle, small divisor
module i2rd_div import i2rd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [DIGIT_W-1:0]    rem_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    trial;
  logic                  fits;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits  = trial >= divisor_i;

  // step sequencing
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(VALUE_BITS);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? DIGIT_W'(trial - divisor_i) : DIGIT_W'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // quotient and remainder
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/i2rd_checker.sv -----
// port level checks for the radix digit converter, bound to the top level
module i2rd_checker import i2rd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DIGIT_W-1:0]    digit_value_o,
  input logic                  is_minus_sign_o,
  input logic                  last_o
);

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_value_o)
      && $stable(is_minus_sign_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // a stalled input beat holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> $stable(value_i))
    else $error("stalled input beat changed");

  // the sign beat carries a zero digit and never closes a run
  a_sign_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_minus_sign_o |-> digit_value_o == '0 && !last_o)
    else $error("malformed sign beat");

  // an accepted input closes the input side on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a conversion runs");

  // an accepted sign beat is never followed straight by another sign beat
  a_one_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_minus_sign_o |=> !(out_valid_o && is_minus_sign_o))
    else $error("repeated sign beat");

endmodule

bind integer_to_radix_digits i2rd_checker #(.VALUE_BITS(VALUE_BITS)) u_i2rd_checker (.*);

// ----- bench/radix_digit_checker.sv -----
// scoreboard for the radix digit stream: predicts every digit beat and checks it
`timescale 1ns / 1ps
module radix_digit_checker import i2rd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RADIX_W-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [DIGIT_W-1:0]    digit_value_i,
  input  logic                  is_minus_sign_i,
  input  logic                  last_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_minus;
    logic               is_last;
  } digit_beat_t;

  // predicted beats, oldest first
  digit_beat_t digit_queue [$];
  logic [RADIX_W-1:0] radix_copy;

  // turn one integer into its expected beats: sign first, then digits msd first
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                         input logic [RADIX_W-1:0] r);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [DIGIT_W-1:0]    digs [VALUE_BITS];
    int                    n;
    digit_beat_t           b;
    // out-of-range radix saturates to the nearest legal base
    if (r < RADIX_MIN) base = VALUE_BITS'(RADIX_MIN);
    else if (r > RADIX_MAX) base = VALUE_BITS'(RADIX_MAX);
    else base = VALUE_BITS'(r);
    // two's complement negate; the most negative value lands on 2^(n-1) unsigned
    mag = v[VALUE_BITS-1] ? -v : v;
    n = 0;
    if (mag == '0) begin
      digs[0] = '0;
      n = 1;
    end
    while (mag != '0) begin
      digs[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end
    if (v[VALUE_BITS-1]) begin
      b = '{digit: '0, is_minus: 1'b1, is_last: 1'b0};
      digit_queue.insert(digit_queue.size(), b);
    end
    for (int i = n - 1; i >= 0; i--) begin
      b = '{digit: digs[i], is_minus: 1'b0, is_last: (i == 0)};
      digit_queue.insert(digit_queue.size(), b);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digit_beat_t want;
    if (!rst_ni) begin
      radix_copy = RADIX_RESET;
      digit_queue.delete();
      pending_o = 0;
    end else begin
      // accepted output beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (digit_queue.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected digit beat: digit %0d minus %0b last %0b",
                   $time, digit_value_i, is_minus_sign_i, last_i);
        end else begin
          want = digit_queue.pop_front();
          if (want.digit !== digit_value_i || want.is_minus !== is_minus_sign_i ||
              want.is_last !== last_i) begin
            errors_o++;
            $display("%0t: digit beat mismatch: expected digit %0d minus %0b last %0b,",
                     $time, want.digit, want.is_minus, want.is_last);
            $display("%0t:   actual digit %0d minus %0b last %0b",
                     $time, digit_value_i, is_minus_sign_i, last_i);
          end
        end
      end
      // accepted integer
      if (in_valid_i && !in_stall_i) predict_digits(value_i, radix_copy);
      // radix register write
      if (cfg_we_i) radix_copy = cfg_wdata_i;
      pending_o = digit_queue.size();
    end
  end

endmodule

// ----- bench/integer_to_radix_digits_test.sv -----
// testbench top for the integer to radix digits converter: stimulus and verdict
`timescale 1ns / 1ps
module integer_to_radix_digits_test;
  import i2rd_pkg::*;

  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int unsigned PHASES     = 14;
  localparam int unsigned PHASE_BEATS = 12;

  // fixed radix settings; the last two phases draw a random one
  localparam logic [RADIX_W-1:0] RADIX_PLAN [12] = '{
    5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd3, 5'd7, 5'd8, 5'd12, 5'd15, 5'd10
  };

  // directed integers at the reset radix
  localparam logic [31:0] DIRECTED [13] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
    -32'sd999999999
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [RADIX_W-1:0]    cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [DIGIT_W-1:0]    digit_value_o;
  logic                  is_minus_sign_o;
  logic                  last_o;

  int unsigned pending;
  int unsigned errors;
  bit          quiet;
  int unsigned stall_left;

  integer_to_radix_digits #(.VALUE_BITS(VALUE_BITS)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digit_value_o   (digit_value_o),
    .is_minus_sign_o (is_minus_sign_o),
    .last_o          (last_o)
  );

  radix_digit_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .value_i         (value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digit_value_i   (digit_value_o),
    .is_minus_sign_i (is_minus_sign_o),
    .last_i          (last_o),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(12_000_000);
    $display("** integer_to_radix_digits: FAILED **");
    $finish;
  end

  // receiver backpressure in random bursts, no new burst starts once quiet is set
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // random integer: extremes, short values, shifted values and full-width values
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    int                    kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        case ($urandom_range(0, 4))
          0:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2:       v = '0;
          3:       v = '1;
          default: v = VALUE_BITS'(1);
        endcase
      end
      1, 2, 3: v = VALUE_BITS'($urandom_range(0, 999));
      4, 5:    v = VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
      default: v = VALUE_BITS'($urandom);
    endcase
    if (kind >= 1 && kind <= 5 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // present one integer, optionally after an idle burst, and wait for acceptance
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // the beat is taken, drop valid before the payload moves on
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // drop valid and wait until every predicted beat has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // radix write once the converter is idle
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain();
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [RADIX_W-1:0] r;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    quiet       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed integers at the reset radix
    foreach (DIRECTED[i]) send_value(VALUE_BITS'(DIRECTED[i]));

    // one phase per radix setting: both extremes first, then random integers
    for (int p = 0; p < PHASES; p++) begin
      if (p < 12) r = RADIX_PLAN[p];
      else r = RADIX_W'($urandom_range(0, 31));
      write_radix(r);
      if (p >= PHASES - 2) quiet = 1'b1;
      send_value({1'b1, {(VALUE_BITS-1){1'b0}}});
      send_value({1'b0, {(VALUE_BITS-1){1'b1}}});
      repeat (PHASE_BEATS) send_value(pick_value());
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("** integer_to_radix_digits: PASSED **");
    end else begin
      $display("** integer_to_radix_digits: FAILED **");
    end
    $finish;
  end

endmodule

// ----- integer_to_radix_digits.f -----
src/i2rd_pkg.sv
src/i2rd_div.sv
src/integer_to_radix_digits.sv
src/i2rd_checker.sv
bench/radix_digit_checker.sv
bench/integer_to_radix_digits_test.sv
